// File: rtl/ifp_pkg.sv
// ifp_pkg: shared types and constants for the inverter fault protector.
// No dependencies; imported by every module of the block.

package ifp_pkg;

    localparam int DATA_W  = 16;
    localparam int LIM_W   = 15;
    localparam int FAULT_W = 8;
    localparam int COUNT_W = 4;
    localparam int INDEX_W = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    // fault word bit positions
    localparam int FB_OCU    = 0;
    localparam int FB_OCV    = 1;
    localparam int FB_OCW    = 2;
    localparam int FB_OCBUS  = 3;
    localparam int FB_OV     = 4;
    localparam int FB_UV     = 5;
    localparam int FB_OT     = 6;
    localparam int FB_REPEAT = 7;

    typedef enum logic {
        ACT_CHECK = 1'b0,
        ACT_CLEAR = 1'b1
    } action_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_PROTECT_ENABLE = 3'd0,
        REG_PHASE_LIMIT    = 3'd1,
        REG_BUS_LIMIT      = 3'd2,
        REG_OV_LIMIT       = 3'd3,
        REG_UV_LIMIT       = 3'd4,
        REG_LATCH_MASK     = 3'd5,
        REG_CLEAR_MASK     = 3'd6,
        REG_CLEAR_LIMIT    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic               protect_enable;
        logic [LIM_W-1:0]   phase_current_limit;
        logic [LIM_W-1:0]   bus_current_limit;
        logic [DATA_W-1:0]  overvoltage_limit;
        logic [DATA_W-1:0]  undervoltage_limit;
        logic [FAULT_W-1:0] latch_mask;
        logic [FAULT_W-1:0] clearable_mask;
        logic [COUNT_W-1:0] clear_limit;
    } cfg_t;

    typedef struct packed {
        logic               action;
        logic [DATA_W-1:0]  phase_u_current;
        logic [DATA_W-1:0]  phase_v_current;
        logic [DATA_W-1:0]  phase_w_current;
        logic [DATA_W-1:0]  bus_current;
        logic [DATA_W-1:0]  dc_link_voltage;
        logic               over_temp;
    } item_t;

    typedef struct packed {
        logic [FAULT_W-1:0] fault_code;
        logic               drive_off;
        logic               escalated;
    } result_t;

    // magnitude of a two's complement sample; full negative gives 32768
    function automatic logic [DATA_W-1:0] magnitude(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] m;
        begin
            m = x[DATA_W-1] ? (~x + {{(DATA_W-1){1'b0}}, 1'b1}) : x;
            return m;
        end
    endfunction

endpackage

// File: rtl/ifp_cfg_regs.sv
// ifp_cfg_regs: configuration register file of the inverter fault protector.
// Depends on ifp_pkg for register indexes and the cfg_t bundle.

module ifp_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [ifp_pkg::INDEX_W-1:0]  wr_index,
    input  logic [ifp_pkg::DATA_W-1:0]   wr_data,
    output ifp_pkg::cfg_t                cfg
);
    import ifp_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_PROTECT_ENABLE: cfg_next.protect_enable      = wr_data[0];
                REG_PHASE_LIMIT:    cfg_next.phase_current_limit = wr_data[LIM_W-1:0];
                REG_BUS_LIMIT:      cfg_next.bus_current_limit   = wr_data[LIM_W-1:0];
                REG_OV_LIMIT:       cfg_next.overvoltage_limit   = wr_data;
                REG_UV_LIMIT:       cfg_next.undervoltage_limit  = wr_data;
                REG_LATCH_MASK:     cfg_next.latch_mask          = wr_data[FAULT_W-1:0];
                REG_CLEAR_MASK:     cfg_next.clearable_mask      = wr_data[FAULT_W-1:0];
                REG_CLEAR_LIMIT:    cfg_next.clear_limit         = wr_data[COUNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.protect_enable      <= 1'b0;
            cfg_reg.phase_current_limit <= 15'h7fff;
            cfg_reg.bus_current_limit   <= 15'h7fff;
            cfg_reg.overvoltage_limit   <= 16'hffff;
            cfg_reg.undervoltage_limit  <= 16'h0000;
            cfg_reg.latch_mask          <= 8'h80;
            cfg_reg.clearable_mask      <= 8'h7f;
            cfg_reg.clear_limit         <= 4'd5;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ifp_detect.sv
// ifp_detect: compares one item's samples against the limits and forms the new fault bits.
// Depends on ifp_pkg for item_t, cfg_t and fault bit positions.

module ifp_detect (
    input  ifp_pkg::item_t               item,
    input  ifp_pkg::cfg_t                cfg,
    output logic [ifp_pkg::FAULT_W-1:0]  found
);
    import ifp_pkg::*;

    logic [DATA_W-1:0] phase_lim;
    logic [DATA_W-1:0] bus_lim;

    assign phase_lim = {1'b0, cfg.phase_current_limit};
    assign bus_lim   = {1'b0, cfg.bus_current_limit};

    always_comb
    begin
        found            = '0;
        found[FB_OCU]    = magnitude(item.phase_u_current) > phase_lim;
        found[FB_OCV]    = magnitude(item.phase_v_current) > phase_lim;
        found[FB_OCW]    = magnitude(item.phase_w_current) > phase_lim;
        found[FB_OCBUS]  = magnitude(item.bus_current) > bus_lim;
        found[FB_OV]     = item.dc_link_voltage > cfg.overvoltage_limit;
        found[FB_UV]     = item.dc_link_voltage < cfg.undervoltage_limit;
        found[FB_OT]     = item.over_temp;
        found[FB_REPEAT] = 1'b0;
    end

endmodule

// File: rtl/ifp_latch.sv
// ifp_latch: fault word and clear counter, updated once per item, and the item's result.
// Depends on ifp_pkg for cfg_t, result_t and fault bit positions.

module ifp_latch (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic                         action,
    input  logic [ifp_pkg::FAULT_W-1:0]  found,
    input  ifp_pkg::cfg_t                cfg,
    output ifp_pkg::result_t             result
);
    import ifp_pkg::*;

    logic [FAULT_W-1:0] fault_word_reg;
    logic [FAULT_W-1:0] fault_word_next;
    logic [COUNT_W-1:0] clears_done_reg;
    logic [COUNT_W-1:0] clears_done_next;

    logic [FAULT_W-1:0] keep_mask;
    logic [COUNT_W-1:0] clears_inc;
    logic               can_clear;
    logic               refuse;

    always_comb
    begin
        keep_mask            = cfg.latch_mask;
        keep_mask[FB_REPEAT] = 1'b1;
        can_clear  = (fault_word_reg & cfg.clearable_mask) != '0;
        clears_inc = (clears_done_reg < COUNT_MAX) ? clears_done_reg + 1'b1 : clears_done_reg;
        refuse     = clears_inc > cfg.clear_limit;

        fault_word_next  = fault_word_reg;
        clears_done_next = clears_done_reg;
        result.drive_off = 1'b0;
        result.escalated = 1'b0;

        case (action_t'(action))
            ACT_CHECK:
            begin
                if (cfg.protect_enable)
                begin
                    fault_word_next  = (fault_word_reg & keep_mask) | found;
                    result.drive_off = fault_word_next != '0;
                end
            end
            ACT_CLEAR:
            begin
                if (can_clear)
                begin
                    clears_done_next = clears_inc;
                    if (refuse)
                    begin
                        fault_word_next            = fault_word_reg;
                        fault_word_next[FB_REPEAT] = 1'b1;
                        result.escalated           = 1'b1;
                    end
                    else
                    begin
                        fault_word_next = fault_word_reg & ~cfg.clearable_mask;
                    end
                end
            end
            default:
            begin
                fault_word_next = fault_word_reg;
            end
        endcase

        result.fault_code = fault_word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_word_reg  <= '0;
            clears_done_reg <= '0;
        end
        else if (step)
        begin
            fault_word_reg  <= fault_word_next;
            clears_done_reg <= clears_done_next;
        end
    end

endmodule

// File: rtl/inverter_fault_protector.sv
// inverter_fault_protector: top level, input register, result register and handshakes.
// Depends on ifp_pkg, ifp_cfg_regs, ifp_detect and ifp_latch.

// One item per clock cycle sustained while out_stall is low: the item is registered, then limit
// compares, the fault latch update and the clear counter are combinational between the item
// register and the result register. A check with protection enabled compares the three phase
// currents and the bus current by magnitude and the bus voltage against both limits; a clear
// removes clearable bits and escalates to the repeat bit, which checks keep, after clear_limit clears.
// The configuration port is always ready; write only while no item is in flight.

module inverter_fault_protector (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         action,
    input  logic signed [ifp_pkg::DATA_W-1:0] phase_u_current,
    input  logic signed [ifp_pkg::DATA_W-1:0] phase_v_current,
    input  logic signed [ifp_pkg::DATA_W-1:0] phase_w_current,
    input  logic signed [ifp_pkg::DATA_W-1:0] bus_current,
    input  logic [ifp_pkg::DATA_W-1:0]   dc_link_voltage,
    input  logic                         over_temp,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ifp_pkg::FAULT_W-1:0]  fault_code,
    output logic                         drive_off,
    output logic                         escalated,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ifp_pkg::INDEX_W-1:0]  cfg_index,
    input  logic [ifp_pkg::DATA_W-1:0]   cfg_data
);
    import ifp_pkg::*;

    cfg_t               cfg;
    item_t              item_reg;
    logic               item_valid_reg;
    result_t            result_reg;
    logic               out_valid_reg;
    result_t            result_next;
    logic [FAULT_W-1:0] found;
    logic               out_load;
    logic               in_load;

    assign cfg_ready = 1'b1;

    ifp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ifp_detect u_detect (
        .item  (item_reg),
        .cfg   (cfg),
        .found (found)
    );

    ifp_latch u_latch (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (out_load),
        .action (item_reg.action),
        .found  (found),
        .cfg    (cfg),
        .result (result_next)
    );

    // result register frees when empty or taken this cycle
    assign out_load = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_load  = in_valid && !in_stall;
    assign in_stall = item_valid_reg && !out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_load)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (out_load)
            begin
                item_valid_reg <= 1'b0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            item_reg.action          <= action;
            item_reg.phase_u_current <= phase_u_current;
            item_reg.phase_v_current <= phase_v_current;
            item_reg.phase_w_current <= phase_w_current;
            item_reg.bus_current     <= bus_current;
            item_reg.dc_link_voltage <= dc_link_voltage;
            item_reg.over_temp       <= over_temp;
        end
        if (out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fault_code = result_reg.fault_code;
    assign drive_off  = result_reg.drive_off;
    assign escalated  = result_reg.escalated;

`ifndef ASSERT_OFF
    a_drive_off_has_fault: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && drive_off |-> fault_code != '0)
        else $error("drive_off with empty fault word");

    a_escalated_sets_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && escalated |-> fault_code[FB_REPEAT])
        else $error("escalated result without repeat bit");

    a_no_drive_off_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(drive_off && escalated))
        else $error("drive_off and escalated in one result");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled while pipeline can advance");
`endif

endmodule

// File: tb/ifp_checker.sv
// ifp_checker: watches the item, result and register channels of the fault protector,
// predicts each fault report and compares it with what the block returns.
// Depends on ifp_pkg.

module ifp_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic                        action,
    input  logic [ifp_pkg::DATA_W-1:0]  phase_u_current,
    input  logic [ifp_pkg::DATA_W-1:0]  phase_v_current,
    input  logic [ifp_pkg::DATA_W-1:0]  phase_w_current,
    input  logic [ifp_pkg::DATA_W-1:0]  bus_current,
    input  logic [ifp_pkg::DATA_W-1:0]  dc_link_voltage,
    input  logic                        over_temp,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic [ifp_pkg::FAULT_W-1:0] fault_code,
    input  logic                        drive_off,
    input  logic                        escalated,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [ifp_pkg::INDEX_W-1:0] cfg_index,
    input  logic [ifp_pkg::DATA_W-1:0]  cfg_data,
    output int                          outstanding,
    output int                          fail_count
);
    import ifp_pkg::*;

    cfg_t               settings;
    logic [FAULT_W-1:0] fault_state;
    logic [COUNT_W-1:0] clears_model;
    result_t            reports_due[$];
    item_t              seen_item;

    assign seen_item = {action, phase_u_current, phase_v_current, phase_w_current,
                        bus_current, dc_link_voltage, over_temp};

    // one extra bit so that full negative comes out as 32768
    function automatic logic [DATA_W:0] sample_magnitude(logic [DATA_W-1:0] s);
        return s[DATA_W-1] ? ({1'b1, {DATA_W{1'b0}}} - {1'b0, s}) : {1'b0, s};
    endfunction

    function automatic result_t assess_item(item_t it);
        result_t            r;
        logic [FAULT_W-1:0] found;
        r = '0;
        found = '0;
        if (it.action == ACT_CHECK)
        begin
            if (settings.protect_enable)
            begin
                found[FB_OCU]   = sample_magnitude(it.phase_u_current) >
                                  settings.phase_current_limit;
                found[FB_OCV]   = sample_magnitude(it.phase_v_current) >
                                  settings.phase_current_limit;
                found[FB_OCW]   = sample_magnitude(it.phase_w_current) >
                                  settings.phase_current_limit;
                found[FB_OCBUS] = sample_magnitude(it.bus_current) > settings.bus_current_limit;
                found[FB_OV]    = it.dc_link_voltage > settings.overvoltage_limit;
                found[FB_UV]    = it.dc_link_voltage < settings.undervoltage_limit;
                found[FB_OT]    = it.over_temp;
                // repeat bit survives every check
                fault_state = (fault_state & (settings.latch_mask | (8'h1 << FB_REPEAT))) | found;
                r.drive_off = |fault_state;
            end
        end
        else if (|(fault_state & settings.clearable_mask))
        begin
            if (clears_model != COUNT_MAX)
                clears_model = clears_model + 1'b1;
            if (clears_model > settings.clear_limit)
            begin
                fault_state[FB_REPEAT] = 1'b1;
                r.escalated = 1'b1;
            end
            else
                fault_state = fault_state & ~settings.clearable_mask;
        end
        r.fault_code = fault_state;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            settings = '{protect_enable: 1'b0, phase_current_limit: 15'h7FFF,
                         bus_current_limit: 15'h7FFF, overvoltage_limit: 16'hFFFF,
                         undervoltage_limit: 16'h0000, latch_mask: 8'h80,
                         clearable_mask: 8'h7F, clear_limit: 4'd5};
            fault_state = '0;
            clears_model = '0;
            reports_due.delete();
            fail_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PROTECT_ENABLE: settings.protect_enable      = cfg_data[0];
                    REG_PHASE_LIMIT:    settings.phase_current_limit = cfg_data[LIM_W-1:0];
                    REG_BUS_LIMIT:      settings.bus_current_limit   = cfg_data[LIM_W-1:0];
                    REG_OV_LIMIT:       settings.overvoltage_limit   = cfg_data;
                    REG_UV_LIMIT:       settings.undervoltage_limit  = cfg_data;
                    REG_LATCH_MASK:     settings.latch_mask          = cfg_data[FAULT_W-1:0];
                    REG_CLEAR_MASK:     settings.clearable_mask      = cfg_data[FAULT_W-1:0];
                    REG_CLEAR_LIMIT:    settings.clear_limit         = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            // results first: a result can never belong to the item taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("result with no item pending: fault_code %02h", fault_code);
                    fail_count++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (fault_code !== want.fault_code)
                    begin
                        $error("fault_code: expected %02h, actual %02h",
                               want.fault_code, fault_code);
                        fail_count++;
                    end
                    if (drive_off !== want.drive_off)
                    begin
                        $error("drive_off: expected %0b, actual %0b", want.drive_off, drive_off);
                        fail_count++;
                    end
                    if (escalated !== want.escalated)
                    begin
                        $error("escalated: expected %0b, actual %0b", want.escalated, escalated);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                reports_due.push_back(assess_item(seen_item));
            outstanding <= reports_due.size();
        end
    end

endmodule

// File: tb/tb.sv
// tb: drives checks, clears and register writes into the inverter fault protector,
// with random idling on both sides, and gives the verdict. Depends on ifp_pkg,
// inverter_fault_protector and ifp_checker.

module tb;
    import ifp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 160;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               action = 1'b0;
    logic [DATA_W-1:0]  phase_u_current = '0;
    logic [DATA_W-1:0]  phase_v_current = '0;
    logic [DATA_W-1:0]  phase_w_current = '0;
    logic [DATA_W-1:0]  bus_current = '0;
    logic [DATA_W-1:0]  dc_link_voltage = '0;
    logic               over_temp = 1'b0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [FAULT_W-1:0] fault_code;
    logic               drive_off;
    logic               escalated;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [DATA_W-1:0]  cfg_data = '0;
    int                 outstanding;
    int                 fail_count;

    // stimulus shaping: limits currently programmed, idling rate
    int   phase_lim = 32767;
    int   bus_lim = 32767;
    int   ov_lim = 65535;
    int   uv_lim = 0;
    int   idle_pct = 20;
    logic steady_tail = 1'b0;
    int   stall_left = 0;
    int   idle_cycles = 0;

    inverter_fault_protector u_dut (.*);
    ifp_checker u_checker (.*);

    always #5 clk = ~clk;

    // receiver stalls in bursts, started at random at the idling rate
    always @(posedge clk)
    begin
        if (steady_tail || idle_pct == 0)
            out_stall <= 1'b0;
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 5);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(reg_index_t idx, logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PHASE_LIMIT: phase_lim = data[LIM_W-1:0];
            REG_BUS_LIMIT:   bus_lim = data[LIM_W-1:0];
            REG_OV_LIMIT:    ov_lim = data;
            REG_UV_LIMIT:    uv_lim = data;
            default: ;
        endcase
    endtask

    task automatic send_item(action_t act, logic [DATA_W-1:0] iu, logic [DATA_W-1:0] iv,
                             logic [DATA_W-1:0] iw, logic [DATA_W-1:0] ib,
                             logic [DATA_W-1:0] vb, logic ot);
        if (!steady_tail && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        phase_u_current <= iu;
        phase_v_current <= iv;
        phase_w_current <= iw;
        bus_current <= ib;
        dc_link_voltage <= vb;
        over_temp <= ot;
        do @(posedge clk); while (in_stall);
    endtask

    // hold the sender until every report has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    function automatic logic [DATA_W-1:0] pick_current(int lim);
        int m;
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3, 4:
            begin
                m = lim + $urandom_range(0, 2) - 1;
                if (m < 0)
                    m = 0;
                return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_voltage();
        case ($urandom_range(0, 7))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2, 3: return 16'(ov_lim + $urandom_range(0, 2) - 1);
            4, 5: return 16'(uv_lim + $urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_item();
        action_t act;
        act = ($urandom_range(0, 3) == 0) ? ACT_CLEAR : ACT_CHECK;
        send_item(act, pick_current(phase_lim), pick_current(phase_lim),
                  pick_current(phase_lim), pick_current(bus_lim), pick_voltage(),
                  $urandom_range(0, 7) == 0);
    endtask

    // random settings, all lows, or all highs; one phase runs with protection off
    task automatic set_phase(int p);
        logic [DATA_W-1:0] v [8];
        for (int i = 0; i < 8; i++)
        begin
            case (p % 3)
                0:       v[i] = 16'($urandom);
                1:       v[i] = 16'h0000;
                default: v[i] = 16'hFFFF;
            endcase
        end
        v[REG_PROTECT_ENABLE] = (p == 2) ? 16'h0000 : (v[REG_PROTECT_ENABLE] | 16'h0001);
        for (int i = 0; i < 8; i++)
            write_reg(reg_index_t'(i), v[i]);
        idle_pct = (p % 4 == 0) ? 0 : 15 + 10 * (p % 3);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // protection still off after reset, then a clear with nothing latched
        send_item(ACT_CHECK, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1'b1);
        send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        drain();
        write_reg(REG_PROTECT_ENABLE, 16'd1);
        write_reg(REG_PHASE_LIMIT, 16'd1000);
        write_reg(REG_BUS_LIMIT, 16'd2000);
        write_reg(REG_OV_LIMIT, 16'd50000);
        write_reg(REG_UV_LIMIT, 16'd10000);
        write_reg(REG_CLEAR_LIMIT, 16'd1);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd30000, 1'b0);
        send_item(ACT_CHECK, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'd30000, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'd30000, 1'b0);
        send_item(ACT_CHECK, 16'd1000, 16'h0000, -16'sd1001, 16'h0000, 16'd30000, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'd30000, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd30000, 1'b1);
        send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_CHECK, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 1'b1);
        // second clear goes past the limit and sets the repeat bit
        send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd30000, 1'b0);
        drain();
        write_reg(REG_LATCH_MASK, 16'd0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd30000, 1'b0);
        send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        drain();
        // repeat bit made clearable, no escalation
        write_reg(REG_CLEAR_MASK, 16'h00FF);
        write_reg(REG_CLEAR_LIMIT, 16'd15);
        send_item(ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
        send_item(ACT_CHECK, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd30000, 1'b0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            set_phase(p);
            steady_tail = (p == PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                random_item();
                if ($urandom_range(0, 59) == 0)
                    drain();
            end
            drain();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/ifp_pkg.sv
rtl/ifp_cfg_regs.sv
rtl/ifp_detect.sv
rtl/ifp_latch.sv
rtl/inverter_fault_protector.sv
tb/ifp_checker.sv
tb/tb.sv
